@@ rtl/qoi_pixel_chunk_encoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// qoi pixel chunk encoder - assertion macros
// shared check macros, sampled on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef QOI_PIXEL_CHUNK_ENCODER_CORE_DEFINES_SVH
`define QOI_PIXEL_CHUNK_ENCODER_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define QPE_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent that must hold in the same cycle as the antecedent
`define QPE_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/qpe_pkg.sv @@
// ----------------------------------------------------------------------------
// qpe_pkg
// types, opcodes and the colour hash shared by the qoi chunk encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpe_pkg;

    // chunk opcodes
    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;

    localparam logic [5:0] RUN_MAX   = 6'd62;
    localparam int         HASH_W    = 6;
    localparam int         IDX_DEPTH = 64;
    localparam int         CHUNK_MAX = 5;
    localparam int         PAD_LEN   = 8;
    localparam int         MAX_BYTES = 14;
    localparam int         CNT_W     = 4;

    // channel_count value that takes the input alpha
    localparam logic [2:0] CH_RGBA = 3'd4;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    localparam pixel_t PREV_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    // bytes caused by one pixel: optional run byte, chunk bytes, optional padding
    typedef struct packed {
        logic                          run_en;
        logic [7:0]                    run_byte;
        logic [2:0]                    n_bytes;
        logic [CHUNK_MAX-1:0][7:0]     bytes;
        logic                          pad;
    } chunk_t;

    // (3r + 5g + 7b + 11a) mod 64, only the low six bits of each channel matter
    function automatic logic [HASH_W-1:0] color_hash(input pixel_t p);
        logic [HASH_W-1:0] h;
        h = p.r[HASH_W-1:0] * 6'd3 + p.g[HASH_W-1:0] * 6'd5
          + p.b[HASH_W-1:0] * 6'd7 + p.a[HASH_W-1:0] * 6'd11;
        return h;
    endfunction

endpackage

@@ rtl/qpe_index.sv @@
// ----------------------------------------------------------------------------
// qpe_index
// 64-entry colour index with valid bits, registered read and write bypass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpe_index (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [qpe_pkg::HASH_W-1:0]  rd_addr,
    input  logic                        wr_en,
    input  logic [qpe_pkg::HASH_W-1:0]  wr_addr,
    input  qpe_pkg::pixel_t             wr_data,
    input  logic                        clear,
    output qpe_pkg::pixel_t             rd_data,
    output logic                        rd_valid
);

    qpe_pkg::pixel_t                    mem [qpe_pkg::IDX_DEPTH];
    logic [qpe_pkg::IDX_DEPTH-1:0]      valid_reg;
    qpe_pkg::pixel_t                    rd_data_reg;
    logic                               rd_valid_reg;
    logic                               bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bypass ? wr_data : mem[rd_addr];
        end
    end

    // a clear drops every entry at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= !clear && (bypass || valid_reg[rd_addr]);
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ rtl/qpe_chunk.sv @@
// ----------------------------------------------------------------------------
// qpe_chunk
// chooses the chunk kind for one pixel and forms its bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpe_chunk (
    input  qpe_pkg::pixel_t             px,
    input  qpe_pkg::pixel_t             prev,
    input  logic [5:0]                  run,
    input  logic [qpe_pkg::HASH_W-1:0]  hash,
    input  logic                        hit,
    input  logic                        final_px,
    output qpe_pkg::chunk_t             chunk,
    output logic [5:0]                  run_next,
    output logic                        idx_wr
);

    logic              same;
    logic [5:0]        run_inc;
    logic signed [7:0] vr;
    logic signed [7:0] vg;
    logic signed [7:0] vb;
    logic signed [7:0] vgr;
    logic signed [7:0] vgb;
    logic [7:0]        dr_b;
    logic [7:0]        dg_b;
    logic [7:0]        db_b;
    logic [7:0]        lg_b;
    logic [7:0]        lr_b;
    logic [7:0]        lb_b;
    logic              is_diff;
    logic              is_luma;

    always_comb
    begin
        same    = (px == prev);
        run_inc = run + 6'd1;

        // channel differences wrap to signed bytes
        vr  = px.r - prev.r;
        vg  = px.g - prev.g;
        vb  = px.b - prev.b;
        vgr = vr - vg;
        vgb = vb - vg;

        dr_b = vr + 8'd2;
        dg_b = vg + 8'd2;
        db_b = vb + 8'd2;
        lg_b = vg + 8'd32;
        lr_b = vgr + 8'd8;
        lb_b = vgb + 8'd8;

        is_diff = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
               && (vb >= -8'sd2) && (vb <= 8'sd1);
        is_luma = (vgr >= -8'sd8) && (vgr <= 8'sd7) && (vg >= -8'sd32) && (vg <= 8'sd31)
               && (vgb >= -8'sd8) && (vgb <= 8'sd7);

        chunk          = '0;
        chunk.pad      = final_px;
        chunk.run_byte = qpe_pkg::OP_RUN | {2'b00, run - 6'd1};
        run_next       = 6'd0;
        idx_wr         = 1'b0;

        if (same)
        begin
            // pixel repeats: grow the run, flush at the limit or at image end
            run_next       = run_inc;
            chunk.run_byte = qpe_pkg::OP_RUN | {2'b00, run};
            if ((run_inc == qpe_pkg::RUN_MAX) || final_px)
            begin
                chunk.run_en = 1'b1;
                run_next     = 6'd0;
            end
        end
        else
        begin
            chunk.run_en = (run != 6'd0);
            if (hit)
            begin
                chunk.n_bytes  = 3'd1;
                chunk.bytes[0] = qpe_pkg::OP_INDEX | {2'b00, hash};
            end
            else
            begin
                idx_wr = 1'b1;
                if (px.a == prev.a)
                begin
                    if (is_diff)
                    begin
                        chunk.n_bytes  = 3'd1;
                        chunk.bytes[0] = qpe_pkg::OP_DIFF
                                       | {2'b00, dr_b[1:0], dg_b[1:0], db_b[1:0]};
                    end
                    else if (is_luma)
                    begin
                        chunk.n_bytes  = 3'd2;
                        chunk.bytes[0] = qpe_pkg::OP_LUMA | {2'b00, lg_b[5:0]};
                        chunk.bytes[1] = {lr_b[3:0], lb_b[3:0]};
                    end
                    else
                    begin
                        chunk.n_bytes  = 3'd4;
                        chunk.bytes[0] = qpe_pkg::OP_RGB;
                        chunk.bytes[1] = px.r;
                        chunk.bytes[2] = px.g;
                        chunk.bytes[3] = px.b;
                    end
                end
                else
                begin
                    chunk.n_bytes  = 3'd5;
                    chunk.bytes[0] = qpe_pkg::OP_RGBA;
                    chunk.bytes[1] = px.r;
                    chunk.bytes[2] = px.g;
                    chunk.bytes[3] = px.b;
                    chunk.bytes[4] = px.a;
                end
            end
        end
    end

endmodule

@@ rtl/qpe_ser.sv @@
// ----------------------------------------------------------------------------
// qpe_ser
// output shift register that sends the bytes of one pixel one at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpe_ser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  qpe_pkg::chunk_t  chunk,
    output logic             can_load,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int CW = qpe_pkg::CNT_W;
    localparam int MB = qpe_pkg::MAX_BYTES;

    logic [7:0]    buf_reg  [MB];
    logic [7:0]    fill     [MB];
    logic [CW-1:0] rel      [MB];
    logic [CW-1:0] pad_pos  [MB];
    logic [CW-1:0] cnt_reg;
    logic          pad_reg;
    logic [CW-1:0] total;
    logic [CW-1:0] run_cnt;
    logic [CW-1:0] chunk_cnt;
    logic          pop;

    always_comb
    begin
        run_cnt   = {{(CW-1){1'b0}}, chunk.run_en};
        chunk_cnt = CW'(chunk.n_bytes);
        total     = run_cnt + chunk_cnt + (chunk.pad ? CW'(qpe_pkg::PAD_LEN) : '0);
        // run byte first, then the chunk, then the padding
        for (int i = 0; i < MB; i++)
        begin
            rel[i]     = CW'(i) - run_cnt;
            pad_pos[i] = rel[i] - chunk_cnt;
            if (CW'(i) < run_cnt)
            begin
                fill[i] = chunk.run_byte;
            end
            else if (rel[i] < chunk_cnt)
            begin
                fill[i] = chunk.bytes[rel[i][2:0]];
            end
            else
            begin
                fill[i] = (pad_pos[i] == CW'(qpe_pkg::PAD_LEN - 1)) ? 8'h01 : 8'h00;
            end
        end
    end

    assign pop      = m_axis_tvalid && m_axis_tready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pad_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg <= total;
            pad_reg <= chunk.pad;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= fill;
        end
        else if (pop)
        begin
            for (int i = 0; i < MB - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = buf_reg[0];
    assign m_axis_tuser  = (cnt_reg == CW'(1));
    assign m_axis_tlast  = (cnt_reg == CW'(1)) && pad_reg;

endmodule

@@ rtl/qoi_pixel_chunk_encoder_core.sv @@
// a pixel is held in the input register, then loaded into the output shift register once that can take its bytes
// throughput: one pixel per cycle while each pixel causes at most one byte and the output is not stalled; a pixel that
//   causes n bytes holds the output shift register until all n are sent (up to 14 with padding)
// the index lookup is one registered read of a 64-entry memory, bypassed on a same-hash write
// reset: channel_count returns to 4, previous pixel to 0,0,0,255, run to 0, index all empty;
//   no clearing pass, the index valid bits clear at once
// ----------------------------------------------------------------------------
// qoi_pixel_chunk_encoder_core
// qoi chunk encoder: rgba pixel items in, encoded chunk byte items out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "qoi_pixel_chunk_encoder_core_defines.svh"

module qoi_pixel_chunk_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: channel_count
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_wdata,
    // pixel items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic        s_axis_tlast,   // final_pixel
    // byte items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    output logic        m_axis_tuser,   // last_of_run [0]
    output logic        m_axis_tlast    // end_of_image
);

    // configuration
    logic [2:0]                   ch_reg;

    // input register: the pixel under work and its index read
    logic                         stage_valid_reg;
    qpe_pkg::pixel_t              px_reg;
    logic                         final_reg;
    logic [qpe_pkg::HASH_W-1:0]   hash_reg;

    // per-image state
    qpe_pkg::pixel_t              prev_reg;
    qpe_pkg::pixel_t              prev_next;
    logic [5:0]                   run_reg;
    logic [5:0]                   run_next;

    qpe_pkg::pixel_t              in_px;
    logic [qpe_pkg::HASH_W-1:0]   in_hash;
    logic                         accept;
    logic                         fire;
    logic                         can_load;

    qpe_pkg::pixel_t              idx_data;
    logic                         idx_valid;
    logic                         hit;
    logic                         idx_wr;
    qpe_pkg::chunk_t              chunk;

    // closing padding byte on the output, per-image state at its start
    logic                         eoi_byte;
    logic                         image_start;

    // alpha is forced opaque unless four channels are selected
    always_comb
    begin
        in_px.r = s_axis_tdata[7:0];
        in_px.g = s_axis_tdata[15:8];
        in_px.b = s_axis_tdata[23:16];
        in_px.a = (ch_reg == qpe_pkg::CH_RGBA) ? s_axis_tdata[31:24] : 8'hFF;
        in_hash = qpe_pkg::color_hash(in_px);
    end

    // the pixel under work moves on once the output register can take its bytes
    assign fire          = stage_valid_reg && can_load;
    assign s_axis_tready = !stage_valid_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= qpe_pkg::CH_RGBA;
        end
        else if (cfg_wen)
        begin
            ch_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= in_px;
            final_reg <= s_axis_tlast;
            hash_reg  <= in_hash;
        end
    end

    // end of image puts the previous pixel back to opaque black
    assign prev_next = final_reg ? qpe_pkg::PREV_RESET : px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= qpe_pkg::PREV_RESET;
            run_reg  <= 6'd0;
        end
        else if (fire)
        begin
            prev_reg <= prev_next;
            run_reg  <= run_next;
        end
    end

    // colour index: read at accept, written and cleared when the pixel moves on
    qpe_index u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (in_hash),
        .wr_en    (fire && idx_wr),
        .wr_addr  (hash_reg),
        .wr_data  (px_reg),
        .clear    (fire && final_reg),
        .rd_data  (idx_data),
        .rd_valid (idx_valid)
    );

    // an entry never written since the image began reads as zero
    assign hit = ((idx_valid ? idx_data : '0) == px_reg);

    qpe_chunk u_chunk (
        .px       (px_reg),
        .prev     (prev_reg),
        .run      (run_reg),
        .hash     (hash_reg),
        .hit      (hit),
        .final_px (final_reg),
        .chunk    (chunk),
        .run_next (run_next),
        .idx_wr   (idx_wr)
    );

    qpe_ser u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .chunk         (chunk),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign eoi_byte    = m_axis_tvalid && m_axis_tlast;
    assign image_start = (run_reg == 6'd0) && (prev_reg == qpe_pkg::PREV_RESET);

    // the closing padding byte is always the last byte of its pixel
    `QPE_IMPLY(a_eoi_is_last, eoi_byte, m_axis_tuser, "end of image byte not last of its pixel")
    // while the padding drains the per-image state is already back at its start
    `QPE_IMPLY(a_eoi_state, eoi_byte, image_start, "image state not restored at end of image")
    // a run is always flushed before it reaches the limit
    `QPE_CHECK(a_run_bound, run_reg < qpe_pkg::RUN_MAX, "run length reached its limit unflushed")

endmodule
